// ===== design/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants of the autoranging prescale counter.
// ----------------------------------------------------------------------------
package apc_pkg;

	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned FACTOR_W = 7;
	localparam int unsigned SW_W     = 3;

	// coarse range comes from count bits above this position
	localparam int unsigned RANGE_SHIFT = 19;
	localparam int unsigned COARSE_W    = COUNT_W - RANGE_SHIFT;

	localparam logic [COARSE_W-1:0] COARSE_LIM_LO = COARSE_W'(2);
	localparam logic [COARSE_W-1:0] COARSE_LIM_MID = COARSE_W'(4);

	// prescale factors
	localparam logic [FACTOR_W-1:0] FACTOR_DIRECT = FACTOR_W'(1);
	localparam logic [FACTOR_W-1:0] FACTOR_LO     = FACTOR_W'(20);
	localparam logic [FACTOR_W-1:0] FACTOR_MID    = FACTOR_W'(40);
	localparam logic [FACTOR_W-1:0] FACTOR_HI     = FACTOR_W'(80);

	// switch line patterns, bit 0 is line 1
	localparam logic [SW_W-1:0] SW_OFF    = 3'b000;
	localparam logic [SW_W-1:0] SW_LO_SEL = 3'b110;
	localparam logic [SW_W-1:0] SW_MID_SEL = 3'b100;
	localparam logic [SW_W-1:0] SW_HI_SEL = 3'b000;

	typedef enum logic {
		PH_RANGING  = 1'b0,
		PH_MEASURING = 1'b1
	} phase_t;

	// one result word before packing
	typedef struct packed {
		logic [COUNT_W-1:0]  frequency;
		logic                frequency_valid;
		logic [FACTOR_W-1:0] prescale_factor;
		logic [SW_W-1:0]     switch_lines;
		logic                next_measuring;
	} result_t;

endpackage

// ===== design/apc_step.sv =====
// ----------------------------------------------------------------------------
// apc_step
// Phase state, prescale factor and switch lines, plus the result of one count.
// ----------------------------------------------------------------------------
module apc_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [apc_pkg::COUNT_W-1:0]   count,
	input  logic                          band,
	output apc_pkg::result_t              res
);

	apc_pkg::phase_t                 phase_q, phase_d;
	logic [apc_pkg::FACTOR_W-1:0]    factor_q, factor_d;
	logic [apc_pkg::SW_W-1:0]        sw_q, sw_d;
	logic [apc_pkg::COARSE_W-1:0]    coarse;
	logic [apc_pkg::COUNT_W-1:0]     prod;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= apc_pkg::PH_RANGING;
			factor_q <= apc_pkg::FACTOR_DIRECT;
			sw_q     <= apc_pkg::SW_OFF;
		end else if (en) begin
			phase_q  <= phase_d;
			factor_q <= factor_d;
			sw_q     <= sw_d;
		end
	end

	assign coarse = count[apc_pkg::COUNT_W-1:apc_pkg::RANGE_SHIFT];
	// count times current factor, wraps to 32 bits
	assign prod = count * apc_pkg::COUNT_W'(factor_q);

	// next phase, factor, switches and result
	always_comb begin
		phase_d  = phase_q;
		factor_d = factor_q;
		sw_d     = sw_q;
		res.frequency       = '0;
		res.frequency_valid = 1'b0;
		case (phase_q)
			apc_pkg::PH_MEASURING: begin
				res.frequency       = prod;
				res.frequency_valid = 1'b1;
				sw_d                = apc_pkg::SW_OFF;
				if (!band) begin
					factor_d = apc_pkg::FACTOR_DIRECT;
					phase_d  = apc_pkg::PH_MEASURING;
				end else begin
					phase_d  = apc_pkg::PH_RANGING;
				end
			end
			apc_pkg::PH_RANGING: begin
				if (coarse <= apc_pkg::COARSE_LIM_LO) begin
					factor_d = apc_pkg::FACTOR_LO;
					sw_d     = apc_pkg::SW_LO_SEL;
				end else if (coarse <= apc_pkg::COARSE_LIM_MID) begin
					factor_d = apc_pkg::FACTOR_MID;
					sw_d     = apc_pkg::SW_MID_SEL;
				end else begin
					factor_d = apc_pkg::FACTOR_HI;
					sw_d     = apc_pkg::SW_HI_SEL;
				end
				phase_d = apc_pkg::PH_MEASURING;
			end
			default: begin
				phase_d = apc_pkg::PH_RANGING;
			end
		endcase
		res.prescale_factor = factor_d;
		res.switch_lines    = sw_d;
		res.next_measuring  = (phase_d == apc_pkg::PH_MEASURING);
	end

endmodule

// ===== design/autoranging_prescale_counter.sv =====
// ----------------------------------------------------------------------------
// autoranging_prescale_counter
// Each input word is one gate-period count; the block alternates between a
// ranging step, which picks a prescale factor of 20, 40 or 80 from the count
// and drives the three prescaler switch lines, and a measuring step, which
// reports count times the factor wrapped to 32 bits. In the measuring phase a
// band input of 0 keeps the block measuring with factor 1, a 1 sends it back
// to ranging. One word is taken per clock cycle when the output side keeps
// up; each word passes through the input register, the combinational
// 32 by 7 multiply and the result register before its result is offered.
// While a finished result waits in the result register,
// the input register takes one more word and then holds the input side until
// the result is taken.
// ----------------------------------------------------------------------------
module autoranging_prescale_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// overflow_count[15:0], timer_high_byte[23:16], timer_low_byte[31:24]
	input  logic [31:0] s_axis_tdata,
	// high_band_select[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frequency[31:0], prescale_factor[38:32], switch_one[39], switch_two[40],
	// switch_three[41], next_measuring[42], zero[47:43]
	output logic [47:0] m_axis_tdata,
	// frequency_valid[0]
	output logic        m_axis_tuser
);

	logic                         valid_s1;
	logic [apc_pkg::COUNT_W-1:0]  count_s1;
	logic                         band_s1;
	logic                         advance;
	logic                         out_valid_q;
	apc_pkg::result_t             res;
	apc_pkg::result_t             res_q;

	// word moves from input register to result register
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload, count assembled from the three fields
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			count_s1 <= {s_axis_tdata[15:0], s_axis_tdata[23:16], s_axis_tdata[31:24]};
			band_s1  <= s_axis_tuser;
		end
	end

	apc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.count  (count_s1),
		.band   (band_s1),
		.res    (res)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.frequency_valid;
	assign m_axis_tdata  = {5'd0, res_q.next_measuring, res_q.switch_lines,
		res_q.prescale_factor, res_q.frequency};

endmodule

// ===== tb/autoranging_prescale_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autoranging_prescale_counter_tb
// Drives gate-period counts into the counter and checks every result word
// against a cycle-free prediction of the ranging and measuring phases. A
// directed run covers the range boundaries, the band input in both phases and
// product wraparound. It is followed by random counts spread over the three
// ranges, with random idling on both stream sides in all but the last pass.
// ----------------------------------------------------------------------------
module autoranging_prescale_counter_tb;

	localparam int unsigned RANDOM_PER_PASS = 533;
	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned DRAIN_CYCLES    = 10;

	// predicts each result word and checks the words that come back
	class reading_scoreboard;
		apc_pkg::phase_t              phase;
		logic [apc_pkg::FACTOR_W-1:0] factor;
		logic [apc_pkg::SW_W-1:0]     sw;
		apc_pkg::result_t             expected_readings[$];
		int unsigned                  errors;
		int unsigned                  n_checked;
		int unsigned                  n_measured;

		function new();
			phase      = apc_pkg::PH_RANGING;
			factor     = apc_pkg::FACTOR_DIRECT;
			sw         = apc_pkg::SW_OFF;
			errors     = 0;
			n_checked  = 0;
			n_measured = 0;
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch at reading %0d: %s got 0x%0h expected 0x%0h",
				n_checked, what, got, want);
			errors++;
		endtask

		// one accepted gate count gives exactly one reading
		function void note_gate_count(logic [apc_pkg::COUNT_W-1:0] count, logic band);
			apc_pkg::result_t             want;
			logic [apc_pkg::COARSE_W-1:0] coarse;
			want   = '0;
			coarse = count[apc_pkg::COUNT_W-1:apc_pkg::RANGE_SHIFT];
			if (phase == apc_pkg::PH_MEASURING) begin
				// product uses the factor chosen before this step
				want.frequency       = count * apc_pkg::COUNT_W'(factor);
				want.frequency_valid = 1'b1;
				sw = apc_pkg::SW_OFF;
				if (band == 1'b0) begin
					factor = apc_pkg::FACTOR_DIRECT;
				end else begin
					phase = apc_pkg::PH_RANGING;
				end
			end else begin
				// ranging ignores the band input
				if (coarse <= apc_pkg::COARSE_LIM_LO) begin
					factor = apc_pkg::FACTOR_LO;
					sw     = apc_pkg::SW_LO_SEL;
				end else if (coarse <= apc_pkg::COARSE_LIM_MID) begin
					factor = apc_pkg::FACTOR_MID;
					sw     = apc_pkg::SW_MID_SEL;
				end else begin
					factor = apc_pkg::FACTOR_HI;
					sw     = apc_pkg::SW_HI_SEL;
				end
				phase = apc_pkg::PH_MEASURING;
			end
			want.prescale_factor = factor;
			want.switch_lines    = sw;
			want.next_measuring  = (phase == apc_pkg::PH_MEASURING);
			expected_readings.push_back(want);
		endfunction

		task check_reading(logic [47:0] word, logic valid_flag);
			apc_pkg::result_t want;
			if (expected_readings.size() == 0) begin
				report_mismatch("word with nothing pending", 64'(word), 64'd0);
				return;
			end
			want = expected_readings.pop_front();
			if (word[31:0] !== want.frequency)
				report_mismatch("frequency", 64'(word[31:0]), 64'(want.frequency));
			if (valid_flag !== want.frequency_valid)
				report_mismatch("frequency_valid", 64'(valid_flag),
					64'(want.frequency_valid));
			if (word[38:32] !== want.prescale_factor)
				report_mismatch("prescale_factor", 64'(word[38:32]),
					64'(want.prescale_factor));
			if (word[39] !== want.switch_lines[0])
				report_mismatch("switch_one", 64'(word[39]), 64'(want.switch_lines[0]));
			if (word[40] !== want.switch_lines[1])
				report_mismatch("switch_two", 64'(word[40]), 64'(want.switch_lines[1]));
			if (word[41] !== want.switch_lines[2])
				report_mismatch("switch_three", 64'(word[41]), 64'(want.switch_lines[2]));
			if (word[42] !== want.next_measuring)
				report_mismatch("next_measuring", 64'(word[42]),
					64'(want.next_measuring));
			if (word[47:43] !== 5'b0)
				report_mismatch("pad bits", 64'(word[47:43]), 64'd0);
			if (want.frequency_valid)
				n_measured++;
			n_checked++;
		endtask

		function int unsigned pending();
			return expected_readings.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	reading_scoreboard sb;
	int unsigned       tx_idle_pct;
	int unsigned       rx_idle_pct;
	int unsigned       n_sent;
	int unsigned       cycles;

	autoranging_prescale_counter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// cycle count and watchdog
	initial begin
		cycles = 0;
		repeat (CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d readings still pending",
			cycles, sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stalls, check every accepted word
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_reading(m_axis_tdata, m_axis_tuser);
			@(negedge clk);
			m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// offer one gate count and hold it until taken
	task automatic send_gate_count(input logic [15:0] ovf, input logic [7:0] hi,
			input logic [7:0] lo, input logic band);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = $urandom;
			s_axis_tuser  = 1'($urandom_range(1));
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {lo, hi, ovf};
		s_axis_tuser  = band;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_gate_count({ovf, hi, lo}, band);
		n_sent++;
		@(negedge clk);
	endtask

	// random count, mostly spread over the three ranges
	task automatic send_random_count();
		logic [15:0] ovf;
		case ($urandom_range(3))
			0: ovf = 16'($urandom_range(0, 23));
			1: ovf = 16'($urandom_range(24, 39));
			2: ovf = 16'($urandom_range(40, 47));
			default: ovf = 16'($urandom);
		endcase
		send_gate_count(ovf, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
	endtask

	initial begin
		sb            = new();
		n_sent        = 0;
		tx_idle_pct   = 33;
		rx_idle_pct   = 53;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: range boundaries, band input in both phases, wraparound
		send_gate_count(16'h0000, 8'h00, 8'h00, 1'b1); // ranging, zero count
		send_gate_count(16'hffff, 8'hff, 8'hff, 1'b0); // wrap with factor 20
		send_gate_count(16'hffff, 8'hff, 8'hff, 1'b0); // direct measure
		send_gate_count(16'h0001, 8'h23, 8'h45, 1'b1); // back to ranging
		send_gate_count(16'h0017, 8'hff, 8'hff, 1'b0); // top of low range
		send_gate_count(16'h0017, 8'hff, 8'hff, 1'b1);
		send_gate_count(16'h0018, 8'h00, 8'h00, 1'b1); // bottom of mid range
		send_gate_count(16'hffff, 8'hff, 8'hff, 1'b1); // wrap with factor 40
		send_gate_count(16'h0027, 8'hff, 8'hff, 1'b0); // top of mid range
		send_gate_count(16'h0027, 8'hff, 8'hff, 1'b1);
		send_gate_count(16'h0028, 8'h00, 8'h00, 1'b0); // bottom of high range
		send_gate_count(16'hffff, 8'hff, 8'hff, 1'b1); // wrap with factor 80
		send_gate_count(16'hffff, 8'hff, 8'hff, 1'b1); // highest count ranging
		send_gate_count(16'h0000, 8'h00, 8'h00, 1'b0); // zero product
		send_gate_count(16'haaaa, 8'h55, 8'haa, 1'b0);
		send_gate_count(16'h5555, 8'haa, 8'h55, 1'b0);
		send_gate_count(16'h8000, 8'h80, 8'h80, 1'b1);
		send_gate_count(16'h5555, 8'haa, 8'h55, 1'b1);
		send_gate_count(16'h0000, 8'h00, 8'h01, 1'b1);

		// random: three idling patterns, the last with no idling
		for (int pass = 0; pass < 3; pass++) begin
			tx_idle_pct = (pass == 0) ? 33 : (pass == 1) ? 53 : 0;
			rx_idle_pct = (pass == 0) ? 53 : (pass == 1) ? 33 : 0;
			for (int i = 0; i < RANDOM_PER_PASS; i++)
				send_random_count();
		end
		s_axis_tvalid = 1'b0;

		// drain and watch for stray words
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d gate counts, checked %0d readings (%0d frequency readings)",
			n_sent, sb.n_checked, sb.n_measured);
		$display("finished after %0d cycles with %0d mismatches", cycles, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== autoranging_prescale_counter.f =====
design/apc_pkg.sv
design/apc_step.sv
design/autoranging_prescale_counter.sv
tb/autoranging_prescale_counter_tb.sv
